[sv/lcdseq_pkg.sv]
// Shared types, command codes and bus constants for the LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdseq_pkg;

    // Command codes carried in the opcode field of an input word.
    typedef enum logic [2:0] {
        OP_CHAR      = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_HOME      = 3'd2,
        OP_SHIFT     = 3'd3,
        OP_LIGHT_ON  = 3'd4,
        OP_LIGHT_OFF = 3'd5,
        OP_INIT      = 3'd6,
        OP_READ      = 3'd7
    } opcode_t;

    // Delay codes that follow a strobe.
    localparam logic [2:0] WAIT_50US   = 3'd0;
    localparam logic [2:0] WAIT_200US  = 3'd1;
    localparam logic [2:0] WAIT_2MS    = 3'd2;
    localparam logic [2:0] WAIT_5MS    = 3'd3;
    localparam logic [2:0] WAIT_POWER  = 3'd4;

    // Controller command bytes.
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISP_OFF     = 8'h08;
    localparam logic [7:0] CMD_DISP_ON      = 8'h0C;
    localparam logic [7:0] CMD_DISP_CURSOR  = 8'h0F;
    localparam logic [7:0] CMD_SHIFT_BASE   = 8'h10;
    localparam logic [7:0] CMD_FUNC_SET     = 8'h28;
    localparam logic [7:0] CMD_CURSOR_ROW1  = 8'hC0;
    localparam logic [3:0] NIB_WAKE         = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_LAST   = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // Input word.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic       shift_display;
        logic       shift_right;
        logic [4:0] read_index;
        logic       string_end;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic       bus_valid;
        logic [3:0] nibble;
        logic       reg_select;
        logic [2:0] wait_code;
        logic       backlight;
        logic [7:0] read_char;
        logic [5:0] fill_count;
        logic [1:0] cur_row;
        logic       dropped;
        logic       last;
    } out_t;

    // What the back end has to emit for one input word.
    typedef enum logic [1:0] {
        JOB_NONE, // one result without bus traffic
        JOB_BYTE, // one byte, two strobes
        JOB_WRAP, // row-two cursor command, then a character
        JOB_INIT  // power-on sequence, sixteen strobes
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       rs;
        logic [2:0] wait_last;
        logic       backlight;
        logic [7:0] read_char;
        logic [5:0] fill_count;
        logic [1:0] cur_row;
        logic       dropped;
    } job_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic [2:0] wait_code;
    } init_strobe_t;

    // Power-on sequence: three wake nibbles, the switch to four-bit mode, then
    // function set, display off, clear, entry mode, display on and cursor on.
    function automatic init_strobe_t init_strobe(logic [3:0] idx);
        init_strobe_t s;
        unique case (idx)
            4'd0:  s = '{NIB_WAKE, WAIT_POWER};
            4'd1:  s = '{NIB_WAKE, WAIT_200US};
            4'd2:  s = '{NIB_WAKE, WAIT_200US};
            4'd3:  s = '{NIB_FOUR_BIT, WAIT_200US};
            4'd4:  s = '{CMD_FUNC_SET[7:4], WAIT_50US};
            4'd5:  s = '{CMD_FUNC_SET[3:0], WAIT_200US};
            4'd6:  s = '{CMD_DISP_OFF[7:4], WAIT_50US};
            4'd7:  s = '{CMD_DISP_OFF[3:0], WAIT_200US};
            4'd8:  s = '{CMD_CLEAR[7:4], WAIT_50US};
            4'd9:  s = '{CMD_CLEAR[3:0], WAIT_2MS};
            4'd10: s = '{CMD_ENTRY_MODE[7:4], WAIT_50US};
            4'd11: s = '{CMD_ENTRY_MODE[3:0], WAIT_200US};
            4'd12: s = '{CMD_DISP_ON[7:4], WAIT_50US};
            4'd13: s = '{CMD_DISP_ON[3:0], WAIT_50US};
            4'd14: s = '{CMD_DISP_CURSOR[7:4], WAIT_50US};
            4'd15: s = '{CMD_DISP_CURSOR[3:0], WAIT_200US};
        endcase
        return s;
    endfunction

    // Result word number idx of a job.
    function automatic out_t job_strobe(job_t job, logic [3:0] idx);
        out_t         r;
        init_strobe_t s;
        r.bus_valid  = 1'b1;
        r.nibble     = 4'h0;
        r.reg_select = 1'b0;
        r.wait_code  = WAIT_50US;
        r.backlight  = job.backlight;
        r.read_char  = job.read_char;
        r.fill_count = job.fill_count;
        r.cur_row    = job.cur_row;
        r.dropped    = job.dropped;
        r.last       = 1'b0;
        s            = init_strobe(idx);
        unique case (job.kind)
            JOB_NONE:
            begin
                r.bus_valid = 1'b0;
                r.last      = 1'b1;
            end
            JOB_BYTE:
            begin
                r.nibble     = idx[0] ? job.data[3:0] : job.data[7:4];
                r.reg_select = job.rs;
                if (idx[0])
                begin
                    r.wait_code = job.wait_last;
                    r.last      = 1'b1;
                end
            end
            JOB_WRAP:
            begin
                if (idx[1])
                begin
                    r.nibble     = idx[0] ? job.data[3:0] : job.data[7:4];
                    r.reg_select = 1'b1;
                    r.last       = idx[0];
                end
                else
                begin
                    r.nibble = idx[0] ? CMD_CURSOR_ROW1[3:0] : CMD_CURSOR_ROW1[7:4];
                end
            end
            JOB_INIT:
            begin
                r.nibble    = s.nibble;
                r.wait_code = s.wait_code;
                r.last      = (idx == 4'hF);
            end
        endcase
        return r;
    endfunction

endpackage

[sv/lcdseq_stream_if.sv]
// Valid/ready channel that carries one payload word per handshake.
`timescale 1ns / 1ps

interface lcdseq_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/lcdseq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lcdseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[sv/lcdseq_front.sv]
// Front end: accepts words, updates text store and status, builds jobs.
`timescale 1ns / 1ps

module lcdseq_front #(
    parameter int STORE_BYTES = 32,
    parameter int LINE_CHARS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lcdseq_stream_if.sink                      cmd,
    input  logic [$clog2(lcdseq_pkg::QUEUE_DEPTH+1)-1:0] q_level,
    output logic                               push_valid,
    output lcdseq_pkg::job_t                   push_job
);
    import lcdseq_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    row_reg, row_next;
    logic          light_reg, light_next;
    logic          s1_valid_reg;
    job_t          s1_job_reg;
    logic          s1_hit_reg;

    job_t          job;
    logic          hit;
    logic          wr_en;
    logic          accept;
    logic          store_full;
    logic          line_full;
    logic [LW:0]   committed;
    logic [7:0]    ram_q;

    // Room is reserved for the word already in the staging register.
    assign committed  = {1'b0, q_level} + {{LW{1'b0}}, s1_valid_reg};
    assign cmd.ready  = (committed < (LW + 1)'(QUEUE_DEPTH));
    assign accept     = cmd.valid && cmd.ready;
    assign store_full = (count_reg >= CW'(STORE_BYTES));
    assign line_full  = (32'(count_reg) >= 32'(LINE_CHARS));

    always_comb
    begin
        count_next    = count_reg;
        row_next      = row_reg;
        light_next    = light_reg;
        wr_en         = 1'b0;
        hit           = 1'b0;
        job.kind      = JOB_NONE;
        job.data      = 8'h00;
        job.rs        = 1'b0;
        job.wait_last = WAIT_2MS;
        job.dropped   = 1'b0;
        if (accept)
        begin
            unique case (opcode_t'(cmd.payload.opcode))
                OP_CHAR:
                begin
                    if (store_full)
                    begin
                        job.dropped = 1'b1;
                    end
                    else if (cmd.payload.char_code == CHAR_NEWLINE)
                    begin
                        if (row_reg < ROW_LAST)
                        begin
                            row_next = row_reg + 2'd1;
                        end
                        wr_en         = 1'b1;
                        count_next    = count_reg + CW'(1);
                        job.wait_last = WAIT_50US;
                        if (row_next == ROW_SECOND)
                        begin
                            job.kind = JOB_BYTE;
                            job.data = CMD_CURSOR_ROW1;
                        end
                    end
                    else
                    begin
                        if (row_reg == ROW_FIRST && line_full)
                        begin
                            row_next = ROW_SECOND;
                            job.kind = JOB_WRAP;
                        end
                        else
                        begin
                            job.kind = JOB_BYTE;
                        end
                        job.data      = cmd.payload.char_code;
                        job.rs        = 1'b1;
                        job.wait_last = WAIT_50US;
                        wr_en         = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    row_next   = ROW_FIRST;
                    job.kind   = JOB_BYTE;
                    job.data   = CMD_CLEAR;
                end
                OP_HOME:
                begin
                    job.kind = JOB_BYTE;
                    job.data = CMD_HOME;
                end
                OP_SHIFT:
                begin
                    job.kind = JOB_BYTE;
                    job.data = CMD_SHIFT_BASE | {4'h0, cmd.payload.shift_display,
                                                 cmd.payload.shift_right, 2'b00};
                end
                OP_LIGHT_ON:
                begin
                    light_next = 1'b1;
                end
                OP_LIGHT_OFF:
                begin
                    light_next = 1'b0;
                end
                OP_INIT:
                begin
                    count_next = '0;
                    row_next   = ROW_FIRST;
                    job.kind   = JOB_INIT;
                end
                OP_READ:
                begin
                    // Positions at or beyond the fill count read as zero.
                    hit = (32'(cmd.payload.read_index) < 32'(count_reg));
                end
            endcase
        end
        job.backlight  = light_next;
        job.read_char  = 8'h00;
        job.fill_count = 6'(count_next);
        job.cur_row    = row_next;
    end

    lcdseq_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd.payload.char_code),
        .rd_addr (AW'(cmd.payload.read_index)),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            row_reg      <= ROW_FIRST;
            light_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            row_reg      <= row_next;
            light_reg    <= light_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_job_reg <= job;
            s1_hit_reg <= hit;
        end
    end

    always_comb
    begin
        push_job           = s1_job_reg;
        push_job.read_char = s1_hit_reg ? ram_q : 8'h00;
    end

    assign push_valid = s1_valid_reg;
endmodule

[sv/lcdseq_queue.sv]
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module lcdseq_queue (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         push_valid,
    input  lcdseq_pkg::job_t                             push_job,
    output logic                                         pop_valid,
    output lcdseq_pkg::job_t                             pop_job,
    input  logic                                         pop,
    output logic [$clog2(lcdseq_pkg::QUEUE_DEPTH+1)-1:0] level
);
    import lcdseq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] level_reg;
    logic          do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push_valid && !do_pop)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (!push_valid && do_pop)
            begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_valid = (level_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign level     = level_reg;
endmodule

[sv/lcdseq_back.sv]
// Back end: steps through a job and presents one result word per cycle while the sink is ready.
`timescale 1ns / 1ps

module lcdseq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  lcdseq_pkg::job_t job,
    output logic             pop,
    lcdseq_stream_if.source  bus
);
    import lcdseq_pkg::*;

    logic [3:0] step_reg;
    logic       out_valid_reg;
    out_t       out_reg;
    out_t       word;
    logic       load;

    assign word = job_strobe(job, step_reg);
    assign load = job_valid && (!out_valid_reg || bus.ready);
    assign pop  = load && word.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= word.last ? 4'd0 : step_reg + 4'd1;
                out_valid_reg <= 1'b1;
            end
            else if (bus.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= word;
        end
    end

    assign bus.valid   = out_valid_reg;
    assign bus.payload = out_reg;
endmodule

[sv/char_lcd_nibble_command_sequencer_core.sv]
// Top level of the character LCD four-bit bus command sequencer.
`timescale 1ns / 1ps
// Path: an accepted input word passes through the front-end staging register and the job queue,
// then its result words are registered in the back end's output register. Throughput: one result
// word per cycle out of the back end while the sink is ready; an input word yields 1, 2, 4 or 16
// result words (non-bus result, byte, wrapped character, power-on sequence), and input is taken
// every cycle while the 4-entry job queue has room. Reset: fill count, row and backlight clear at
// once; no clearing pass, since reads above the fill count return zero.

module char_lcd_nibble_command_sequencer_core #(
    parameter int STORE_BYTES = 32,
    parameter int LINE_CHARS  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    lcdseq_stream_if.sink   cmd,
    lcdseq_stream_if.source bus
);
    import lcdseq_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    // The front end does all state bookkeeping at the accepting edge: it
    // moves the fill count, the row and the backlight, writes the character
    // into the text store and reads the store for a read word. In the next
    // cycle the word, now a job with its status fields and read byte fixed,
    // enters the queue.
    logic          push_valid;
    job_t          push_job;

    // The queue lets the front end keep taking words while the back end is
    // still emitting a long sequence such as the power-on strobes.
    logic          pop_valid;
    job_t          pop_job;
    logic          pop;
    logic [LW-1:0] q_level;

    lcdseq_front #(
        .STORE_BYTES (STORE_BYTES),
        .LINE_CHARS  (LINE_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    lcdseq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop        (pop),
        .level      (q_level)
    );

    // The back end walks the job one strobe at a time into an output
    // register, which keeps the result steady while the sink stalls.
    lcdseq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .pop       (pop),
        .bus       (bus)
    );
endmodule

[sv/lcdseq_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module lcdseq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              valid,
    input logic              ready,
    input lcdseq_pkg::out_t  payload
);
    import lcdseq_pkg::*;

    // A stalled word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(payload))
        else $error("result word changed while stalled");

    // A word without bus traffic is the only word of its item and is blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !payload.bus_valid |-> payload.last && payload.nibble == 4'h0
            && !payload.reg_select && payload.wait_code == WAIT_50US)
        else $error("non-bus result word malformed");

    // Read data and a refused character only show on non-bus words.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (payload.read_char != 8'h00 || payload.dropped) |-> !payload.bus_valid)
        else $error("read data or drop flag on a bus strobe");

    // Data strobes never carry a long wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && payload.bus_valid && payload.reg_select |-> payload.wait_code == WAIT_50US)
        else $error("character strobe with long wait");

    // Wait codes stay within the defined set and the row saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> payload.wait_code <= WAIT_POWER && payload.cur_row <= ROW_LAST)
        else $error("wait code or row out of range");
endmodule

bind char_lcd_nibble_command_sequencer_core lcdseq_checker u_lcdseq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (bus.valid),
    .ready   (bus.ready),
    .payload (bus.payload)
);
